### design/grid_ray_traversal_3d_defines.svh
// assertion macros for the grid ray traversal checker
// expects a clk and an active-high rst in the scope of each use
`ifndef GRID_RAY_TRAVERSAL_3D_DEFINES_SVH
`define GRID_RAY_TRAVERSAL_3D_DEFINES_SVH

// same-cycle implication
`define GRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/grt_pkg.sv
// shared constants, types and fixed-point helpers for the grid ray traversal
// no dependencies
package grt_pkg;

  localparam int MAX_CELLS = 512;
  localparam int FRAC_BITS = 16;
  localparam int CELL_W    = $clog2(MAX_CELLS);
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 33;

  localparam logic signed [31:0] Q_INF = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_NEG = 32'sh8000_0000;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [2:0] {
    REG_LOW_X  = 3'd0,
    REG_LOW_Y  = 3'd1,
    REG_LOW_Z  = 3'd2,
    REG_SIZE_X = 3'd3,
    REG_SIZE_Y = 3'd4,
    REG_SIZE_Z = 3'd5,
    REG_COUNTS = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HI, S_SLAB, S_TA, S_TB, S_CHECK, S_PMUL, S_CELL,
    S_BMUL, S_BDIV, S_DDIV, S_STEP, S_IDX1, S_IDX2, S_DONE
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [NUM_W-1:0] quo;
    logic                    rem_nz;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(Q_INF)) r = Q_INF;
    else if (v < 64'(Q_NEG)) r = Q_NEG;
    else r = 32'(v);
    return r;
  endfunction

  // clamp the numerator, then scale by the fraction bits
  function automatic logic signed [63:0] qscale(input logic signed [63:0] v);
    logic signed [63:0] lim;
    logic signed [63:0] c;
    lim = 64'sd1 <<< (62 - FRAC_BITS);
    c = v;
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    return c <<< FRAC_BITS;
  endfunction

  // count field of 0 acts as 1, above the max acts as the max
  function automatic logic [CNT_W-1:0] cnt_eff(input logic [9:0] f);
    logic [11:0] fx;
    logic [11:0] r;
    fx = {2'b00, f};
    if (fx == 12'd0) r = 12'd1;
    else if (fx > 12'(MAX_CELLS)) r = 12'(MAX_CELLS);
    else r = fx;
    return CNT_W'(r);
  endfunction

endpackage

### design/grid_ray_traversal_3d.sv
// top level of the 3d grid ray walker: registers, sequencer, shared multiplier
// depends on grt_pkg and grt_div
//
// usage
// - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the grid box
//   low corner, cell sizes and packed per-axis counts; cfg_ready is always high,
//   writes are expected only while the block is idle
// - input channel takes one beat per item: opcode 0 starts a ray from origin,
//   direction and ray_tmin, opcode 1 steps one cell along the nearest boundary
// - output channel gives one beat per item: cell, flat index, entry distance,
//   next boundary distance and the alive flag
// - a start runs one shared radix-2 divider up to fifteen times (slab
//   clip, entry cell, boundary distance and delta per axis); a start is
//   shortest for a miss on a flat axis and longest when no direction
//   component is zero
// - a step is one compare and saturating add, then two multiplies on the
//   shared multiplier for the flat index
// - in_ready is high only in the idle state; one item is worked at a time
// - the result sits in an output register; a stalled receiver holds it while
//   the next item is accepted and worked, and that item waits at its end
// - synchronous reset clears the walk state and restores the default grid
module grid_ray_traversal_3d (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] ray_tmin,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         cell_x,
  output logic [8:0]         cell_y,
  output logic [8:0]         cell_z,
  output logic [26:0]        cell_index,
  output logic signed [31:0] t_enter,
  output logic signed [31:0] t_next,
  output logic               alive
);
  import grt_pkg::*;

  // configuration
  logic signed [31:0] grid_low [3];
  logic [30:0]        cell_size [3];
  logic [29:0]        grid_counts;
  logic [CNT_W-1:0]   cnt [3];

  // ray and walk state
  logic signed [31:0] org [3];
  logic signed [31:0] dir [3];
  logic signed [31:0] t0, t1, ta, walk_t;
  logic signed [43:0] hi_r;
  logic signed [51:0] p_r;
  logic [CELL_W-1:0]  cur_cell [3];
  logic signed [1:0]  step_sign [3];
  logic signed [31:0] bdist [3];
  logic signed [31:0] bdelta [3];
  logic               walk_alive;

  // sequencer
  state_t     state, state_next;
  logic [1:0] ax;
  logic       div_wait;
  logic       div_done;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // combinational helpers
  logic signed [43:0] hi_c;
  logic               outside;
  logic signed [51:0] p_c;
  logic signed [63:0] cell_num;
  logic signed [63:0] cell_q;
  logic [CELL_W-1:0]  cell_clamped;
  logic signed [31:0] ta_c, tb_c, tlo, thi;
  logic [1:0]         sel;
  logic signed [CELL_W+1:0] step_c;
  logic               step_exit;
  logic signed [31:0] tn_c;
  logic [CELL_W:0]    cell_up;

  always_comb begin
    for (int a = 0; a < 3; a++) cnt[a] = cnt_eff(grid_counts[10*a +: 10]);
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign div_done  = div_wait && div_rsp.done;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        grid_low[a]  <= '0;
        cell_size[a] <= 31'd65536;
      end
      grid_counts <= 30'd1049601;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_X:  grid_low[0] <= cfg_data;
        REG_LOW_Y:  grid_low[1] <= cfg_data;
        REG_LOW_Z:  grid_low[2] <= cfg_data;
        REG_SIZE_X: cell_size[0] <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
        REG_SIZE_Y: cell_size[1] <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
        REG_SIZE_Z: cell_size[2] <= (cfg_data[30:0] == '0) ? 31'd1 : cfg_data[30:0];
        REG_COUNTS: grid_counts <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  // slab and cell arithmetic around the current axis
  always_comb begin
    hi_c     = 44'(grid_low[ax]) + 44'(prod);
    outside  = (44'(org[ax]) < 44'(grid_low[ax])) || (44'(org[ax]) > hi_c);
    p_c      = 52'(org[ax]) + 52'(prod >>> FRAC_BITS);
    cell_num = 64'(p_r) - 64'(grid_low[ax]);
    // floor from truncation: step down on a negative inexact quotient
    cell_q   = div_rsp.quo - 64'(div_rsp.rem_nz && cell_num[63]);
    if (cell_q < 64'sd0) cell_clamped = '0;
    else if (cell_q > 64'(cnt[ax]) - 64'sd1) cell_clamped = CELL_W'(cnt[ax] - 1'b1);
    else cell_clamped = CELL_W'(cell_q);
    ta_c    = ta;
    tb_c    = sat32(div_rsp.quo);
    tlo     = (ta_c > tb_c) ? tb_c : ta_c;
    thi     = (ta_c > tb_c) ? ta_c : tb_c;
    cell_up = {1'b0, cur_cell[ax]} + (CELL_W+1)'(dir[ax] > 32'sd0);
  end

  // nearest boundary, ties to the lower axis
  always_comb begin
    sel = 2'd0;
    if (bdist[1] < bdist[0]) sel = 2'd1;
    if (bdist[2] < bdist[sel]) sel = 2'd2;
    step_c = $signed((CELL_W+2)'(cur_cell[sel])) + (CELL_W+2)'(step_sign[sel]);
    step_exit = (step_sign[sel] == 2'sd0) || (step_c < 0) ||
                (step_c >= $signed((CELL_W+2)'(cnt[sel])));
    tn_c = bdist[0];
    if (bdist[1] < tn_c) tn_c = bdist[1];
    if (bdist[2] < tn_c) tn_c = bdist[2];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = (opcode == OP_START) ? S_HI : S_STEP;
      S_HI:    state_next = S_SLAB;
      S_SLAB: begin
        if (dir[ax] != 32'sd0) state_next = S_TA;
        else if (outside) state_next = S_IDX1;
        else state_next = (ax == 2'd2) ? S_CHECK : S_HI;
      end
      S_TA:    if (div_done) state_next = S_TB;
      S_TB:    if (div_done) state_next = (ax == 2'd2) ? S_CHECK : S_HI;
      S_CHECK: state_next = (t0 > t1) ? S_IDX1 : S_PMUL;
      S_PMUL:  state_next = S_CELL;
      S_CELL: begin
        if (div_done) begin
          if (dir[ax] != 32'sd0) state_next = S_BMUL;
          else state_next = (ax == 2'd2) ? S_IDX1 : S_PMUL;
        end
      end
      S_BMUL:  state_next = S_BDIV;
      S_BDIV:  if (div_done) state_next = S_DDIV;
      S_DDIV:  if (div_done) state_next = (ax == 2'd2) ? S_IDX1 : S_PMUL;
      S_STEP:  state_next = S_IDX1;
      S_IDX1:  state_next = S_IDX2;
      S_IDX2:  state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // multiplier operands and divider requests
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state)
      S_HI: begin
        mul_a = $signed(33'(cell_size[ax]));
        mul_b = $signed(33'(cnt[ax]));
      end
      S_PMUL: begin
        mul_a = 33'(t0);
        mul_b = 33'(dir[ax]);
      end
      S_BMUL: begin
        mul_a = $signed(33'(cell_up));
        mul_b = $signed(33'(cell_size[ax]));
      end
      S_IDX1: begin
        mul_a = $signed(33'(cur_cell[2]));
        mul_b = $signed(33'(cnt[1]));
      end
      S_IDX2: begin
        mul_a = prod[32:0] + $signed(33'(cur_cell[1]));
        mul_b = $signed(33'(cnt[0]));
      end
      S_TA: begin
        div_req.start = !div_wait;
        div_req.num   = qscale(64'(grid_low[ax]) - 64'(org[ax]));
        div_req.den   = 33'(dir[ax]);
      end
      S_TB: begin
        div_req.start = !div_wait;
        div_req.num   = qscale(64'(hi_r) - 64'(org[ax]));
        div_req.den   = 33'(dir[ax]);
      end
      S_CELL: begin
        div_req.start = !div_wait;
        div_req.num   = 64'(p_c) - 64'(grid_low[ax]);
        div_req.den   = $signed(33'(cell_size[ax]));
      end
      S_BDIV: begin
        div_req.start = !div_wait;
        div_req.num   = qscale(64'(grid_low[ax]) + 64'(prod) - 64'(p_r));
        div_req.den   = 33'(dir[ax]);
      end
      S_DDIV: begin
        div_req.start = !div_wait;
        div_req.num   = qscale($signed(64'(cell_size[ax])));
        div_req.den   = dir[ax][31] ? -33'(dir[ax]) : 33'(dir[ax]);
      end
      default: ;
    endcase
  end

  grt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // the flat index product stays put while the result waits to load
  always_ff @(posedge clk) begin
    if (state != S_DONE) prod <= mul_a * mul_b;
  end

  // sequencer and walk datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      div_wait   <= 1'b0;
      ax         <= '0;
      out_valid  <= 1'b0;
      walk_alive <= 1'b0;
      walk_t     <= '0;
      for (int a = 0; a < 3; a++) begin
        cur_cell[a]  <= '0;
        step_sign[a] <= '0;
        bdist[a]     <= '0;
        bdelta[a]    <= '0;
      end
    end else begin
      state <= state_next;
      if (div_req.start) div_wait <= 1'b1;
      else if (div_done) div_wait <= 1'b0;

      if (state == S_IDLE || state == S_CHECK) ax <= '0;
      else if (state_next == S_HI || state_next == S_PMUL) ax <= ax + 2'd1;

      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid && opcode == OP_START) begin
            org[0] <= origin_x;
            org[1] <= origin_y;
            org[2] <= origin_z;
            dir[0] <= dir_x;
            dir[1] <= dir_y;
            dir[2] <= dir_z;
            t0     <= ray_tmin;
            t1     <= Q_INF;
            // a new ray drops the old walk; a miss leaves it all zero
            walk_alive <= 1'b0;
            walk_t     <= '0;
            for (int a = 0; a < 3; a++) begin
              cur_cell[a]  <= '0;
              step_sign[a] <= '0;
              bdist[a]     <= '0;
              bdelta[a]    <= '0;
            end
          end
        end
        S_SLAB: hi_r <= hi_c;
        S_TA:   if (div_done) ta <= sat32(div_rsp.quo);
        S_TB: begin
          if (div_done) begin
            if (tlo > t0) t0 <= tlo;
            if (thi < t1) t1 <= thi;
          end
        end
        S_CHECK: if (!(t0 > t1)) walk_t <= t0;
        S_CELL: begin
          if (!div_wait) p_r <= p_c;
          if (div_done) begin
            cur_cell[ax] <= cell_clamped;
            if (dir[ax] == 32'sd0) begin
              step_sign[ax] <= 2'sd0;
              bdist[ax]     <= Q_INF;
              bdelta[ax]    <= Q_INF;
              if (ax == 2'd2) walk_alive <= 1'b1;
            end
          end
        end
        S_BDIV: begin
          if (div_done) begin
            bdist[ax]     <= sat32(64'(t0) + 64'(sat32(div_rsp.quo)));
            step_sign[ax] <= (dir[ax] > 32'sd0) ? 2'sd1 : -2'sd1;
          end
        end
        S_DDIV: begin
          if (div_done) begin
            bdelta[ax] <= sat32(div_rsp.quo);
            if (ax == 2'd2) walk_alive <= 1'b1;
          end
        end
        S_STEP: begin
          // dead walks keep their state
          if (walk_alive) begin
            walk_t     <= bdist[sel];
            bdist[sel] <= sat32(64'(bdist[sel]) + 64'(bdelta[sel]));
            if (step_exit) walk_alive <= 1'b0;
            else cur_cell[sel] <= CELL_W'(step_c);
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            cell_x     <= 9'(cur_cell[0]);
            cell_y     <= 9'(cur_cell[1]);
            cell_z     <= 9'(cur_cell[2]);
            cell_index <= prod[26:0] + 27'(cur_cell[0]);
            t_enter    <= walk_t;
            t_next     <= tn_c;
            alive      <= walk_alive;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### design/grt_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
// depends on grt_pkg
module grt_div (
  input  logic            clk,
  input  logic            rst,
  input  grt_pkg::div_req_t req,
  output grt_pkg::div_rsp_t rsp
);
  import grt_pkg::*;

  logic             busy;
  logic             done;
  logic [5:0]       cnt;
  logic [NUM_W-1:0] qr;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] dmag;
  logic             neg;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem[DEN_W-1:0], qr[NUM_W-1]};
  assign fits  = trial >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd63;
        qr   <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
        dmag <= req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
        neg  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
        rem  <= '0;
      end else if (busy) begin
        rem <= fits ? trial - {1'b0, dmag} : trial;
        qr  <= {qr[NUM_W-2:0], fits};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.quo    = neg ? -$signed(qr) : $signed(qr);
  assign rsp.rem_nz = |rem;

endmodule

### design/grt_checker.sv
// port-level checks for the grid ray traversal, bound to the top level
// depends on grid_ray_traversal_3d_defines.svh
`include "grid_ray_traversal_3d_defines.svh"

module grt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [8:0]         cell_x,
  input logic [8:0]         cell_y,
  input logic [8:0]         cell_z,
  input logic [26:0]        cell_index,
  input logic signed [31:0] t_enter,
  input logic signed [31:0] t_next,
  input logic               alive
);

  // stalled result beat holds its flat index, distances and alive flag
  `GRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_index) && $stable(t_enter) && $stable(t_next) && $stable(alive), "result changed while stalled")

  // one item at a time: busy right after an input beat
  `GRT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

  // a result appears as the sequencer returns to idle
  `GRT_ASSERT_NOW(a_load_idle, $rose(out_valid), in_ready, "result loaded outside idle")

  // the origin cell has flat index zero
  `GRT_ASSERT_NOW(a_zero_index, out_valid && cell_x == 9'd0 && cell_y == 9'd0 && cell_z == 9'd0, cell_index == 27'd0, "nonzero index for origin cell")

endmodule

bind grid_ray_traversal_3d grt_checker u_grt_checker (.*);
